FILE: src/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants for the spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none
package mst_pkg;
  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned TOTAL_W   = 21;
  localparam int unsigned COST_W    = 15;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 21'd2097151;
  localparam logic [1:0] ST_FRESH = 2'd0;
  localparam logic [1:0] ST_TAKEN = 2'd1;
  localparam logic [1:0] ST_EXCL  = 2'd2;
endpackage
`default_nettype wire

FILE: src/minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree
// Kruskal spanning tree over loaded edges, union-find links in a memory.
// ----------------------------------------------------------------------------
// Loading: one edge item per cycle while in the load state. After the last
// edge item a run clears the link memory, then per considered edge scans the
// store for the cheapest fresh edge and walks both ends to their roots, then
// a final scan. Output emits one result per taken edge, held through out_ready stalls.
// Reset (synchronous, rst_n low) clears control state and the counters; the
// link memory is cleared by a sweep at the start of each run.
`default_nettype none
module minimum_spanning_tree
  import mst_pkg::*;
#(
  parameter int unsigned MAX_EDGES    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [5:0]  in_vertex_a,
  input  wire logic [5:0]  in_vertex_b,
  input  wire logic [14:0] in_cost,
  input  wire logic        in_last_edge,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_tree_vertex_a,
  output logic [5:0]       out_tree_vertex_b,
  output logic [14:0]      out_tree_cost,
  output logic [20:0]      out_total_cost,
  output logic             out_spanning,
  output logic             out_edge_valid,
  output logic             out_last_result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);
  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SCAND = 4'd3;
  localparam logic [3:0] S_RDA   = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_DECID = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_OUTD  = 4'd8;
  localparam logic [3:0] S_HOLD  = 4'd9;

  // Edge store: one word per edge, status kept separately for writes.
  logic [5:0]        mem_a   [MAX_EDGES];
  logic [5:0]        mem_b   [MAX_EDGES];
  logic [14:0]       mem_w   [MAX_EDGES];
  logic [1:0]        mem_s   [MAX_EDGES];
  // Link memory: valid bit plus parent; cleared bit means root.
  logic [VW:0]       link_m  [MAX_VERTICES];

  logic [3:0]        state_r;
  logic [6:0]        vcnt_r;
  logic [CW-1:0]     loaded_r;
  logic [NW-1:0]     taken_r;
  logic [CW-1:0]     idx_r;      // scan/output address
  logic [EW-1:0]     ridx_r;     // address of the word now on the read port
  logic              rvld_r;
  logic [5:0]        rd_a, rd_b;
  logic [14:0]       rd_w;
  logic [1:0]        rd_s;
  logic              found_r;
  logic [EW-1:0]     best_r;
  logic [14:0]       bcost_r;
  logic [VW-1:0]     cur_r;      // vertex being walked
  logic              side_r;     // 0 walking a, 1 walking b
  logic [VW-1:0]     ra_r;
  logic [VW-1:0]     vb_r;
  logic [VW:0]       lrd_r;
  logic [TOTAL_W-1:0] total_r;
  logic [NW-1:0]     emit_r;
  logic [VW-1:0]     clr_r;

  // Clamp the vertex count to 2..MAX_VERTICES.
  logic [NW-1:0] nv;
  always_comb begin
    if (vcnt_r < 7'd2) nv = NW'(2);
    else if (32'(vcnt_r) > MAX_VERTICES) nv = NW'(MAX_VERTICES);
    else nv = NW'(vcnt_r);
  end

  logic accept_in;
  logic store_ok;
  assign in_ready  = (state_r == S_LOAD);
  assign cfg_ready = (state_r == S_LOAD);
  assign accept_in = in_valid && in_ready;
  assign store_ok  = (32'(loaded_r) < MAX_EDGES) && (NW'(in_vertex_a) < nv)
                   && (NW'(in_vertex_b) < nv);

  logic [EW-1:0] raddr;
  logic          swr;
  logic [EW-1:0] swaddr;
  logic [1:0]    swdata;
  logic [VW-1:0] laddr;
  logic          lwr;
  logic [VW-1:0] lwaddr;
  logic [VW:0]   lwdata;

  always_ff @(posedge clk) begin
    if (accept_in && store_ok) begin
      mem_a[loaded_r[EW-1:0]] <= in_vertex_a;
      mem_b[loaded_r[EW-1:0]] <= in_vertex_b;
      mem_w[loaded_r[EW-1:0]] <= in_cost;
    end
    if (swr) mem_s[swaddr] <= swdata;
    rd_a <= mem_a[raddr];
    rd_b <= mem_b[raddr];
    rd_w <= mem_w[raddr];
    rd_s <= mem_s[raddr];
    if (lwr) link_m[lwaddr] <= lwdata;
    lrd_r <= link_m[laddr];
  end

  logic out_take;
  assign out_take = out_valid && out_ready;
  // One spare bit keeps the sum from wrapping before the saturation compare.
  logic [TOTAL_W:0]   tsum_w;
  logic [TOTAL_W-1:0] tsum;
  assign tsum_w = {1'b0, total_r} + (TOTAL_W+1)'(rd_w);
  assign tsum   = (tsum_w > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum_w[TOTAL_W-1:0];

  always_comb begin
    raddr  = idx_r[EW-1:0];
    swr    = 1'b0;
    swaddr = loaded_r[EW-1:0];
    swdata = ST_FRESH;
    laddr  = cur_r;
    lwr    = 1'b0;
    lwaddr = clr_r;
    lwdata = '0;
    if (accept_in && store_ok) swr = 1'b1;
    if (state_r == S_CLR) lwr = 1'b1;
    if (state_r == S_RDA || state_r == S_SCAND) raddr = best_r;
    if (state_r == S_DECID) begin
      swr    = 1'b1;
      swaddr = best_r;
      swdata = (ra_r == cur_r) ? ST_EXCL : ST_TAKEN;
      if (ra_r != cur_r) begin
        lwr    = 1'b1;
        lwaddr = ra_r;
        lwdata = {1'b1, cur_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      vcnt_r   <= 7'd64;
      loaded_r <= '0;
      taken_r  <= '0;
      idx_r    <= '0;
      rvld_r   <= 1'b0;
      found_r  <= 1'b0;
      clr_r    <= '0;
      out_valid <= 1'b0;
      emit_r   <= '0;
      total_r  <= '0;
      side_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (cfg_valid) vcnt_r <= cfg_data;
          if (accept_in) begin
            if (store_ok) loaded_r <= loaded_r + 1'b1;
            if (in_last_edge) begin
              state_r <= S_CLR;
              clr_r   <= '0;
              taken_r <= '0;
            end
          end
        end
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_VERTICES - 1) begin
            state_r <= S_SCAN;
            idx_r <= '0;
            rvld_r <= 1'b0;
            found_r <= 1'b0;
          end
        end
        S_SCAN: begin
          // Stream the edge store; evaluate the word read last cycle.
          if (rvld_r && rd_s == ST_FRESH && (!found_r || rd_w < bcost_r)) begin
            found_r <= 1'b1;
            best_r  <= ridx_r;
            bcost_r <= rd_w;
          end
          ridx_r <= idx_r[EW-1:0];
          if (idx_r < loaded_r) begin
            rvld_r <= 1'b1;
            idx_r  <= idx_r + 1'b1;
          end else begin
            rvld_r <= 1'b0;
            if (!rvld_r) state_r <= S_SCAND;
          end
        end
        S_SCAND: begin
          if (!found_r || taken_r == nv - 1'b1) begin
            state_r <= S_OUT;
            idx_r <= '0;
            rvld_r <= 1'b0;
            emit_r <= '0;
            total_r <= '0;
          end else state_r <= S_RDA;
        end
        S_RDA: begin
          // Endpoints of best arrive next cycle; start the a-side walk.
          state_r <= S_WALK;
          side_r  <= 1'b0;
          rvld_r  <= 1'b0;
        end
        S_WALK: begin
          if (!rvld_r) begin
            if (!side_r) begin
              cur_r <= VW'(rd_a);
              vb_r  <= VW'(rd_b);
            end
            rvld_r <= 1'b1;
            state_r <= S_HOLD;
          end else if (lrd_r[VW]) begin
            cur_r <= lrd_r[VW-1:0];
            state_r <= S_HOLD;
          end else if (!side_r) begin
            ra_r   <= cur_r;
            side_r <= 1'b1;
            cur_r  <= vb_r;
            state_r <= S_HOLD;
          end else state_r <= S_DECID;
        end
        S_HOLD: state_r <= S_WALK;  // link read latency
        S_DECID: begin
          if (ra_r != cur_r) taken_r <= taken_r + 1'b1;
          state_r <= S_SCAN;
          idx_r <= '0;
          rvld_r <= 1'b0;
          found_r <= 1'b0;
        end
        S_OUT: begin
          if (taken_r == '0) begin
            out_tree_vertex_a <= '0;
            out_tree_vertex_b <= '0;
            out_tree_cost   <= '0;
            out_total_cost  <= '0;
            out_spanning    <= 1'b0;
            out_edge_valid  <= 1'b0;
            out_last_result <= 1'b1;
            out_valid <= 1'b1;
            state_r <= S_OUTD;
          end else if (rvld_r) begin
            rvld_r <= 1'b0;
            if (rd_s == ST_TAKEN) begin
              total_r <= tsum;
              out_tree_vertex_a <= rd_a;
              out_tree_vertex_b <= rd_b;
              out_tree_cost   <= rd_w;
              out_total_cost  <= tsum;
              out_spanning    <= (taken_r == nv - 1'b1);
              out_edge_valid  <= 1'b1;
              out_last_result <= (emit_r + 1'b1 == taken_r);
              emit_r <= emit_r + 1'b1;
              out_valid <= 1'b1;
              state_r <= S_OUTD;
            end
          end else if (idx_r < loaded_r) begin
            idx_r <= idx_r + 1'b1;
            rvld_r <= 1'b1;
          end
        end
        S_OUTD: begin
          if (out_take) begin
            out_valid <= 1'b0;
            if (out_last_result) begin
              state_r  <= S_LOAD;
              loaded_r <= '0;
              taken_r  <= '0;
            end else state_r <= S_OUT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_ready) else $error("input taken during run");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= nv) else $error("too many tree edges");
`endif
endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spanning tree block testbench
// Loads random and hand-picked weighted graphs, predicts the Kruskal tree of
// each one and checks every emitted tree edge, under random stalls on both
// channels and several vertex counts.
// ----------------------------------------------------------------------------
module testbench;
  import mst_pkg::*;

  localparam int NUM_VERTICES = 64;
  localparam int NUM_EDGES    = 256;

  typedef struct {
    logic [5:0]  vertex_a;
    logic [5:0]  vertex_b;
    logic [14:0] cost;
    logic [20:0] total;
    logic        spanning;
    logic        edge_valid;
    logic        last_result;
  } tree_edge_t;

  // Predict the tree of each loaded graph and hold the edges still to come.
  class tree_scoreboard;
    logic [5:0]  end_a [NUM_EDGES];
    logic [5:0]  end_b [NUM_EDGES];
    logic [14:0] weight [NUM_EDGES];
    logic [1:0]  status [NUM_EDGES];
    int          parent [NUM_VERTICES];
    int          loaded;
    logic [6:0]  vertex_count;
    tree_edge_t  tree_queue [$];
    int          errors;

    function new();
      loaded = 0;
      vertex_count = 7'd64;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function int find_root(int v);
      for (int n = 0; n < NUM_VERTICES; n++) begin
        if (parent[v] < 0) break;
        v = parent[v];
      end
      return v;
    endfunction

    function void note_edge(logic [5:0] a, logic [5:0] b, logic [14:0] c, logic last);
      int nv;
      int taken;
      int best;
      int ra;
      int rb;
      int total;
      int k;
      bit found;
      tree_edge_t r;
      nv = vertex_count;
      if (nv < 2) nv = 2;
      if (nv > NUM_VERTICES) nv = NUM_VERTICES;
      if (loaded < NUM_EDGES && a < nv && b < nv) begin
        end_a[loaded] = a;
        end_b[loaded] = b;
        weight[loaded] = c;
        status[loaded] = ST_FRESH;
        loaded++;
      end
      if (!last) return;
      foreach (parent[i]) parent[i] = -1;
      taken = 0;
      while (taken < nv - 1) begin
        found = 0;
        best = 0;
        for (int i = 0; i < loaded; i++)
          if (status[i] == ST_FRESH && (!found || weight[i] < weight[best])) begin
            found = 1;
            best = i;
          end
        if (!found) break;
        ra = find_root(end_a[best]);
        rb = find_root(end_b[best]);
        if (ra == rb) status[best] = ST_EXCL;
        else begin
          parent[ra] = rb;
          status[best] = ST_TAKEN;
          taken++;
        end
      end
      if (taken == 0) begin
        r = '{default: '0};
        r.last_result = 1'b1;
        tree_queue.push_back(r);
      end else begin
        total = 0;
        k = 0;
        for (int i = 0; i < loaded; i++) begin
          if (status[i] != ST_TAKEN) continue;
          total += weight[i];
          if (total > int'(TOTAL_MAX)) total = TOTAL_MAX;
          k++;
          r.vertex_a = end_a[i];
          r.vertex_b = end_b[i];
          r.cost = weight[i];
          r.total = 21'(total);
          r.spanning = (taken == nv - 1);
          r.edge_valid = 1'b1;
          r.last_result = (k == taken);
          tree_queue.push_back(r);
        end
      end
      loaded = 0;
    endfunction

    task check_edge(tree_edge_t got);
      tree_edge_t want;
      if (tree_queue.size() == 0) begin
        report("tree edge with none expected");
        return;
      end
      want = tree_queue.pop_front();
      if (got.vertex_a !== want.vertex_a)
        report($sformatf("vertex_a %0d want %0d", got.vertex_a, want.vertex_a));
      if (got.vertex_b !== want.vertex_b)
        report($sformatf("vertex_b %0d want %0d", got.vertex_b, want.vertex_b));
      if (got.cost !== want.cost)
        report($sformatf("tree_cost %0d want %0d", got.cost, want.cost));
      if (got.total !== want.total)
        report($sformatf("total_cost %0d want %0d", got.total, want.total));
      if (got.spanning !== want.spanning)
        report($sformatf("spanning %0b want %0b", got.spanning, want.spanning));
      if (got.edge_valid !== want.edge_valid)
        report($sformatf("edge_valid %0b want %0b", got.edge_valid, want.edge_valid));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result %0b want %0b", got.last_result, want.last_result));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  in_vertex_a;
  logic [5:0]  in_vertex_b;
  logic [14:0] in_cost;
  logic        in_last_edge;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_tree_vertex_a;
  logic [5:0]  out_tree_vertex_b;
  logic [14:0] out_tree_cost;
  logic [20:0] out_total_cost;
  logic        out_spanning;
  logic        out_edge_valid;
  logic        out_last_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;

  tree_scoreboard sb;
  bit quiet;        // no idling on either side
  bit long_hold;    // ask the receiver for one long stall

  minimum_spanning_tree DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_cost(in_cost), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tree_vertex_a(out_tree_vertex_a), .out_tree_vertex_b(out_tree_vertex_b),
    .out_tree_cost(out_tree_cost), .out_total_cost(out_total_cost),
    .out_spanning(out_spanning), .out_edge_valid(out_edge_valid),
    .out_last_result(out_last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Outputs settle after the rising edge, so sample handshakes at the falling
  // edge; the item is taken at the rising edge that follows.
  always @(negedge clk) begin
    tree_edge_t got;
    if (rst_n && out_valid && out_ready) begin
      got.vertex_a = out_tree_vertex_a;
      got.vertex_b = out_tree_vertex_b;
      got.cost = out_tree_cost;
      got.total = out_total_cost;
      got.spanning = out_spanning;
      got.edge_valid = out_edge_valid;
      got.last_result = out_last_result;
      sb.check_edge(got);
    end
  end

  // Receiver: random ready bursts, one long hold on request, none when quiet.
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 0;
        hold = 600;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(0, 7);
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offer one edge item and hold it until it is taken; unless quiet, sometimes idle a burst first.
  // Valid stays up after the accepting edge; the next item or drain() drops it.
  task send_edge(logic [5:0] a, logic [5:0] b, logic [14:0] c, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_a <= a;
    in_vertex_b <= b;
    in_cost <= c;
    in_last_edge <= last;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_edge(a, b, c, last);
  endtask

  // Drop valid, wait until every tree edge has come, then let the block settle.
  task drain();
    in_valid <= 1'b0;
    while (sb.tree_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_vertex_count(logic [6:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.vertex_count = value;
    cfg_valid <= 1'b0;
  endtask

  function logic [5:0] pick_vertex();
    int nv;
    nv = sb.vertex_count;
    if (nv < 2) nv = 2;
    if (nv > NUM_VERTICES) nv = NUM_VERTICES;
    // Mostly in range; the rest hits any value and is dropped when too big.
    if ($urandom_range(0, 9) != 0) return 6'($urandom_range(0, nv - 1));
    return 6'($urandom);
  endfunction

  // Send one graph of random edges, the final one marked last.
  task send_graph(int n);
    logic [14:0] c;
    for (int i = 0; i < n; i++) begin
      // Small costs give many ties; full-range costs reach the top bits.
      c = ($urandom_range(0, 1) != 0) ? 15'($urandom_range(0, 7)) : 15'($urandom);
      send_edge(pick_vertex(), pick_vertex(), c, i == n - 1);
    end
  endtask

  initial begin
    logic [6:0] counts [8];
    counts = '{7'd2, 7'd3, 7'd5, 7'd8, 7'd0, 7'd127, 7'd16, 7'd64};
    sb = new();
    quiet = 0;
    long_hold = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_vertex_a = '0;
    in_vertex_b = '0;
    in_cost = '0;
    in_last_edge = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme ends and costs, self loop, reversed pair, at reset count.
    send_edge(6'd0, 6'd63, 15'h7FFF, 1'b0);
    send_edge(6'd63, 6'd0, 15'd0, 1'b0);
    send_edge(6'd5, 6'd5, 15'd100, 1'b0);
    send_edge(6'd63, 6'd62, 15'd32766, 1'b1);
    // Four vertices: out-of-range ends dropped, equal costs, a full tree.
    write_vertex_count(7'd4);
    send_edge(6'd4, 6'd1, 15'd1, 1'b0);
    send_edge(6'd0, 6'd1, 15'h7FFF, 1'b0);
    send_edge(6'd1, 6'd2, 15'd5, 1'b0);
    send_edge(6'd2, 6'd3, 15'd5, 1'b0);
    send_edge(6'd0, 6'd3, 15'd5, 1'b0);
    send_edge(6'd0, 6'd2, 15'd1, 1'b1);
    // Only a self loop: nothing is taken.
    send_edge(6'd3, 6'd3, 15'd9, 1'b1);
    // Last mark on a dropped edge with an empty store.
    send_edge(6'd63, 6'd2, 15'd9, 1'b1);
    // Count below the floor clamps to two vertices.
    write_vertex_count(7'd0);
    send_edge(6'd1, 6'd0, 15'd7, 1'b0);
    send_edge(6'd0, 6'd1, 15'd3, 1'b1);
    // Count above the ceiling clamps to all vertices.
    write_vertex_count(7'd127);
    send_edge(6'd63, 6'd31, 15'd2, 1'b1);

    // Random phases at several vertex counts.
    for (int p = 0; p < 10; p++) begin
      write_vertex_count((p < 8) ? counts[p] : 7'($urandom_range(2, 64)));
      repeat (2) send_graph($urandom_range(1, 6));
    end

    // One graph past store capacity at the full vertex count.
    write_vertex_count(7'd64);
    send_graph(258);

    // Hold the receiver off while several graphs queue up behind it.
    write_vertex_count(7'd6);
    long_hold = 1;
    repeat (3) send_graph($urandom_range(3, 8));

    // Sender waits for every tree edge, then a final stretch with no idling.
    drain();
    quiet = 1;
    write_vertex_count(7'd10);
    repeat (3) send_graph($urandom_range(4, 12));

    drain();
    repeat (50) @(posedge clk);
    while (sb.tree_queue.size() != 0) begin
      void'(sb.tree_queue.pop_front());
      sb.report("tree edge never emitted");
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

FILE: minimum_spanning_tree.f
src/mst_pkg.sv
src/minimum_spanning_tree.sv
test/testbench.sv
